// ===== rtl/gated_triangle_lfo_assert.svh =====
// Assertion macros shared by the LFO files.
// GTL_ASSERT_IMP: when a holds, c holds in the same cycle.
// GTL_ASSERT_NXT: when a holds, c holds in the next cycle.
`ifndef GATED_TRIANGLE_LFO_ASSERT_SVH
`define GATED_TRIANGLE_LFO_ASSERT_SVH
`ifndef SYNTHESIS
`define GTL_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gated_triangle_lfo: assertion failed");
`define GTL_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gated_triangle_lfo: assertion failed");
`else
`define GTL_ASSERT_IMP(label, clk, rst, a, c)
`define GTL_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/gtl_pkg.sv =====
package gtl_pkg;

  localparam int PHASE_BITS = 32;
  localparam int OUT_BITS   = 16;
  localparam int FRAC_BITS  = OUT_BITS - 3;
  // folded phase needs headroom for offset add and both folds
  localparam int X_BITS     = PHASE_BITS + 3;
  localparam int SHIFT      = PHASE_BITS - 2 - FRAC_BITS;

  localparam int ADDR_BITS  = 6;
  localparam int DATA_BITS  = 64;
  localparam int IDX_BITS   = 3;

  typedef logic signed [X_BITS-1:0]   x_t;
  typedef logic signed [OUT_BITS-1:0] sample_t;

  localparam x_t ONE_X     = x_t'(64'd1 << (PHASE_BITS - 2));
  localparam x_t TWO_X     = x_t'(64'd1 << (PHASE_BITS - 1));
  localparam x_t NEG_ONE_X = -ONE_X;
  localparam x_t NEG_TWO_X = -TWO_X;

  localparam sample_t MINUS_TWO = sample_t'(-(64'sd2 <<< FRAC_BITS));

  // register indexes, byte address = 8 * index
  typedef enum logic [IDX_BITS-1:0] {
    REG_OUTER_STEP   = 3'd0,
    REG_INNER_STEP   = 3'd1,
    REG_ACTIVE_WIDTH = 3'd2,
    REG_START_OFFSET = 3'd3,
    REG_HOLD_LAST    = 3'd4,
    REG_IDLE_VALUE   = 3'd5,
    REG_SYNC_INNER   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0]        outer_step;
    logic [PHASE_BITS-1:0]        inner_step;
    logic [PHASE_BITS:0]          active_width;
    logic signed [PHASE_BITS:0]   start_offset;
    logic                         hold_last;
    sample_t                      idle_value;
    logic                         sync_inner;
  } cfg_t;

  // per-tick control carried down the pipeline
  typedef struct packed {
    logic restart;
    logic gate;
  } tick_t;

endpackage

// ===== rtl/gtl_phase.sv =====
`include "gated_triangle_lfo_assert.svh"

module gtl_phase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         accept,
  input  logic                         restart,
  input  gtl_pkg::cfg_t                cfg,
  output logic                         s1_valid,
  output gtl_pkg::tick_t               s1_tick,
  output gtl_pkg::x_t                  s1_x
);

  logic [gtl_pkg::PHASE_BITS-1:0] outer_phase, outer_phase_next;
  logic [gtl_pkg::PHASE_BITS-1:0] inner_phase, inner_phase_next;
  logic [gtl_pkg::PHASE_BITS-1:0] outer_eff;
  logic [gtl_pkg::PHASE_BITS:0]   outer_sum;
  logic                           gate;
  logic                           wrap;
  gtl_pkg::x_t                    x;

  always_comb begin
    outer_eff = restart ? '0 : outer_phase;
    gate      = {1'b0, outer_eff} >= cfg.active_width;
    outer_sum = {1'b0, outer_eff} + {1'b0, cfg.outer_step};
    wrap      = outer_sum[gtl_pkg::PHASE_BITS];
    outer_phase_next = outer_sum[gtl_pkg::PHASE_BITS-1:0];
    inner_phase_next = inner_phase;
    if (!gate) begin
      inner_phase_next = inner_phase + cfg.inner_step;
    end
    if (wrap && cfg.sync_inner) begin
      inner_phase_next = '0;
    end
    // triangle source uses the phase before this tick's advance
    x = $signed({{(gtl_pkg::X_BITS-gtl_pkg::PHASE_BITS){1'b0}}, inner_phase})
      + {{(gtl_pkg::X_BITS-gtl_pkg::PHASE_BITS-1){cfg.start_offset[gtl_pkg::PHASE_BITS]}},
         cfg.start_offset};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_phase <= '0;
      inner_phase <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        outer_phase <= outer_phase_next;
        inner_phase <= inner_phase_next;
      end
      if (en) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tick.restart <= restart;
      s1_tick.gate    <= gate;
      s1_x            <= x;
    end
  end

  // a gated tick freezes the inner phase unless a synced wrap clears it
  `GTL_ASSERT_NXT(a_gate_freezes_inner, clk, rst, accept && gate && !(wrap && cfg.sync_inner), inner_phase == $past(inner_phase))
  // restart forces the outer phase to zero, so only a zero width gates
  `GTL_ASSERT_IMP(a_restart_ungated, clk, rst, accept && restart && (cfg.active_width != '0), !gate)

endmodule

// ===== rtl/gated_triangle_lfo.sv =====
// An accepted tick passes three register stages in order, s1, s2 and the output register,
// before its result item can be taken.
// Throughput: one tick per cycle while the output is not stalled; the phase accumulators
// and the gate compare sit in stage 1, and the two folds sit in the following two pipeline stages.
// A stalled output item holds the whole pipeline and stalls the input, bubbles included.
// Reset (rst, synchronous): phases 0, last value -2.0, registers to their defaults.
`include "gated_triangle_lfo_assert.svh"

module gated_triangle_lfo (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gtl_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [gtl_pkg::DATA_BITS-1:0]     pwdata,
  output logic [gtl_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  // tick input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              restart,
  // sample output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gtl_pkg::OUT_BITS-1:0] sample_value,
  output logic                              gated
);

  gtl_pkg::cfg_t     cfg;
  gtl_pkg::reg_idx_t idx;
  logic              wr;

  // pipeline control
  logic              en;
  logic              accept;
  logic              s1_valid, s2_valid;
  gtl_pkg::tick_t    s1_tick, s2_tick;
  gtl_pkg::x_t       s1_x, s2_x, x1, x3;
  gtl_pkg::sample_t  tri_value;
  gtl_pkg::sample_t  last_value;
  gtl_pkg::sample_t  last_eff;
  gtl_pkg::sample_t  res;

  // ---------------------------------------------------------------------------
  // Register file. Registers sit at 8-byte spacing; paddr[5:3] picks one.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = gtl_pkg::reg_idx_t'(paddr[gtl_pkg::ADDR_BITS-1:gtl_pkg::ADDR_BITS-gtl_pkg::IDX_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer_step   <= '0;
      cfg.inner_step   <= '0;
      cfg.active_width <= {1'b1, {gtl_pkg::PHASE_BITS{1'b0}}};  // always active
      cfg.start_offset <= '0;
      cfg.hold_last    <= 1'b0;
      cfg.idle_value   <= gtl_pkg::MINUS_TWO;
      cfg.sync_inner   <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        gtl_pkg::REG_OUTER_STEP:   cfg.outer_step   <= pwdata[gtl_pkg::PHASE_BITS-1:0];
        gtl_pkg::REG_INNER_STEP:   cfg.inner_step   <= pwdata[gtl_pkg::PHASE_BITS-1:0];
        gtl_pkg::REG_ACTIVE_WIDTH: cfg.active_width <= pwdata[gtl_pkg::PHASE_BITS:0];
        gtl_pkg::REG_START_OFFSET: cfg.start_offset <= $signed(pwdata[gtl_pkg::PHASE_BITS:0]);
        gtl_pkg::REG_HOLD_LAST:    cfg.hold_last    <= pwdata[0];
        gtl_pkg::REG_IDLE_VALUE:   cfg.idle_value   <= $signed(pwdata[gtl_pkg::OUT_BITS-1:0]);
        gtl_pkg::REG_SYNC_INNER:   cfg.sync_inner   <= pwdata[0];
        default: ;  // unmapped slot: write dropped
      endcase
    end
  end

  // read-back; signed registers come back sign-extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      gtl_pkg::REG_OUTER_STEP:
        prdata = {{(gtl_pkg::DATA_BITS-gtl_pkg::PHASE_BITS){1'b0}}, cfg.outer_step};
      gtl_pkg::REG_INNER_STEP:
        prdata = {{(gtl_pkg::DATA_BITS-gtl_pkg::PHASE_BITS){1'b0}}, cfg.inner_step};
      gtl_pkg::REG_ACTIVE_WIDTH:
        prdata = {{(gtl_pkg::DATA_BITS-gtl_pkg::PHASE_BITS-1){1'b0}}, cfg.active_width};
      gtl_pkg::REG_START_OFFSET:
        prdata = {{(gtl_pkg::DATA_BITS-gtl_pkg::PHASE_BITS-1){cfg.start_offset[gtl_pkg::PHASE_BITS]}},
                  cfg.start_offset};
      gtl_pkg::REG_HOLD_LAST:
        prdata = {{(gtl_pkg::DATA_BITS-1){1'b0}}, cfg.hold_last};
      gtl_pkg::REG_IDLE_VALUE:
        prdata = {{(gtl_pkg::DATA_BITS-gtl_pkg::OUT_BITS){cfg.idle_value[gtl_pkg::OUT_BITS-1]}},
                  cfg.idle_value};
      gtl_pkg::REG_SYNC_INNER:
        prdata = {{(gtl_pkg::DATA_BITS-1){1'b0}}, cfg.sync_inner};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline moves as one whenever the output register is free or being taken.
  // ---------------------------------------------------------------------------
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // stage 1: phase accumulators, gate decision, x = inner + offset
  gtl_phase u_phase (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .accept   (accept),
    .restart  (restart),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_tick  (s1_tick),
    .s1_x     (s1_x)
  );

  // stage 2: fold at +1
  assign x1 = (s1_x > gtl_pkg::ONE_X) ? (gtl_pkg::TWO_X - s1_x) : s1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_tick <= s1_tick;
      s2_x    <= x1;
    end
  end

  // stage 3: fold at -1, floor to Q3.13 by dropping low bits, pick the output
  assign x3        = (s2_x < gtl_pkg::NEG_ONE_X) ? (gtl_pkg::NEG_TWO_X - s2_x) : s2_x;
  assign tri_value = x3[gtl_pkg::SHIFT+gtl_pkg::OUT_BITS-1:gtl_pkg::SHIFT];
  // restart drops the held value back to -2.0 before this tick
  assign last_eff  = s2_tick.restart ? gtl_pkg::MINUS_TWO : last_value;

  always_comb begin
    if (!s2_tick.gate) begin
      res = tri_value;
    end else if (cfg.hold_last) begin
      res = last_eff;
    end else begin
      res = cfg.idle_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_value <= gtl_pkg::MINUS_TWO;
    end else if (en) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        last_value <= s2_tick.gate ? last_eff : tri_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      sample_value <= res;
      gated        <= s2_tick.gate;
    end
  end

  // after the first fold nothing lies above +1
  `GTL_ASSERT_IMP(a_fold_upper, clk, rst, s2_valid, s2_x <= gtl_pkg::ONE_X)
  // gated items without hold carry the idle level
  `GTL_ASSERT_IMP(a_idle_out, clk, rst, out_valid && gated && !cfg.hold_last,
                  sample_value == cfg.idle_value)

endmodule
